// ----- sv/assert_macros.svh -----
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is high
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds across reset
`define ASSERT_CLK_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/tcb_pkg.sv -----
package tcb_pkg;

   localparam int COLUMNS_DEF = 70;
   localparam int ROWS_DEF    = 26;

   localparam int CHAR_W     = 8;
   localparam int COL_W      = 7;
   localparam int ROW_W      = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 7;

   localparam logic [CHAR_W-1:0] CODE_BS         = 8'h08;
   localparam logic [CHAR_W-1:0] CODE_TAB        = 8'h09;
   localparam logic [CHAR_W-1:0] CODE_NL         = 8'h0a;
   localparam logic [CHAR_W-1:0] CODE_SPACE      = 8'h20;
   localparam logic [CHAR_W-1:0] CODE_LAST_PRINT = 8'h7f;
   localparam logic [CHAR_W-1:0] CODE_NULL       = 8'h00;

   localparam logic [CSR_DATA_W-1:0] TAB_FIRST_RST  = 7'd13;
   localparam logic [CSR_DATA_W-1:0] TAB_SECOND_RST = 7'd25;
   localparam logic [CSR_DATA_W-1:0] TAB_THIRD_RST  = 7'd32;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TAB_FIRST  = 2'd0,
      CSR_TAB_SECOND = 2'd1,
      CSR_TAB_THIRD  = 2'd2
   } csr_index_type;

   typedef enum logic [0:0] {
      OP_PUT  = 1'b0,
      OP_READ = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FILL,
      ST_CHECK,
      ST_SCROLL,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [CSR_DATA_W-1:0] first;
      logic [CSR_DATA_W-1:0] second;
      logic [CSR_DATA_W-1:0] third;
   } tab_stops_type;

endpackage

// ----- sv/text_console_buffer_core.sv -----
// Flow: a read goes from ST_IDLE to ST_DONE; a printable or backspace code goes
// through ST_CHECK, an ignored code straight to ST_DONE; a tab or newline blanks
// cells in ST_FILL, and a scroll blanks the new bottom row in ST_SCROLL.
// Throughput: one transaction at a time, bounded by the single write port of the cell memory.
// Reset: cursor and scroll base go to zero, then a clearing pass writes zero to
// every cell with req_stall high.
module text_console_buffer_core import tcb_pkg::*; #(
   parameter int COLUMNS = COLUMNS_DEF,
   parameter int ROWS    = ROWS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_operation,
   input  logic [CHAR_W-1:0]     req_char_code,
   input  logic [COL_W-1:0]      req_read_col,
   input  logic [ROW_W-1:0]      req_read_row,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [CHAR_W-1:0]     rsp_cell_char,
   output logic [COL_W-1:0]      rsp_cursor_col,
   output logic [ROW_W-1:0]      rsp_cursor_row,
   output logic                  rsp_scrolled,
   output logic                  rsp_ignored
);

   localparam int AW = $clog2(ROWS) + $clog2(COLUMNS);

   tab_stops_type     tab_ff, tab_in;
   logic              mem_wr_en;
   logic [AW-1:0]     mem_wr_addr;
   logic [CHAR_W-1:0] mem_wr_data;
   logic              mem_rd_en;
   logic [AW-1:0]     mem_rd_addr;
   logic [CHAR_W-1:0] mem_rd_data;

   always_comb begin
      tab_in = tab_ff;
      if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_TAB_FIRST:  tab_in.first  = csr_wdata;
            CSR_TAB_SECOND: tab_in.second = csr_wdata;
            CSR_TAB_THIRD:  tab_in.third  = csr_wdata;
            default:        tab_in        = tab_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tab_ff <= '{first: TAB_FIRST_RST, second: TAB_SECOND_RST, third: TAB_THIRD_RST};
      end else begin
         tab_ff <= tab_in;
      end
   end

   tcb_ctrl #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .tab_stops      (tab_ff),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_operation  (req_operation),
      .req_char_code  (req_char_code),
      .req_read_col   (req_read_col),
      .req_read_row   (req_read_row),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_cell_char  (rsp_cell_char),
      .rsp_cursor_col (rsp_cursor_col),
      .rsp_cursor_row (rsp_cursor_row),
      .rsp_scrolled   (rsp_scrolled),
      .rsp_ignored    (rsp_ignored),
      .mem_wr_en      (mem_wr_en),
      .mem_wr_addr    (mem_wr_addr),
      .mem_wr_data    (mem_wr_data),
      .mem_rd_en      (mem_rd_en),
      .mem_rd_addr    (mem_rd_addr),
      .mem_rd_data    (mem_rd_data)
   );

   tcb_store #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule

// ----- sv/tcb_store.sv -----
module tcb_store import tcb_pkg::*; #(
   parameter int COLUMNS = COLUMNS_DEF,
   parameter int ROWS    = ROWS_DEF
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [$clog2(ROWS)+$clog2(COLUMNS)-1:0]    wr_addr,
   input  logic [CHAR_W-1:0]                          wr_data,
   input  logic                                       rd_en,
   input  logic [$clog2(ROWS)+$clog2(COLUMNS)-1:0]    rd_addr,
   output logic [CHAR_W-1:0]                          rd_data
);

   localparam int CAW   = $clog2(COLUMNS);
   localparam int DEPTH = ROWS * (2 ** CAW);

   logic [CHAR_W-1:0] mem_ff [DEPTH];
   logic [CHAR_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/tcb_ctrl.sv -----
module tcb_ctrl import tcb_pkg::*; #(
   parameter int COLUMNS = COLUMNS_DEF,
   parameter int ROWS    = ROWS_DEF
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  tab_stops_type                            tab_stops,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic                                     req_operation,
   input  logic [CHAR_W-1:0]                        req_char_code,
   input  logic [COL_W-1:0]                         req_read_col,
   input  logic [ROW_W-1:0]                         req_read_row,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic [CHAR_W-1:0]                        rsp_cell_char,
   output logic [COL_W-1:0]                         rsp_cursor_col,
   output logic [ROW_W-1:0]                         rsp_cursor_row,
   output logic                                     rsp_scrolled,
   output logic                                     rsp_ignored,
   output logic                                     mem_wr_en,
   output logic [$clog2(ROWS)+$clog2(COLUMNS)-1:0]  mem_wr_addr,
   output logic [CHAR_W-1:0]                        mem_wr_data,
   output logic                                     mem_rd_en,
   output logic [$clog2(ROWS)+$clog2(COLUMNS)-1:0]  mem_rd_addr,
   input  logic [CHAR_W-1:0]                        mem_rd_data
);

   localparam int CAW = $clog2(COLUMNS);
   localparam int RW  = $clog2(ROWS);
   localparam int CNW = $clog2(COLUMNS + 1);
   localparam int RNW = $clog2(ROWS + 1);

   localparam logic [CNW-1:0] COL_END  = CNW'(COLUMNS);
   localparam logic [CNW-1:0] COL_LAST = CNW'(COLUMNS - 1);
   localparam logic [CAW-1:0] CNT_LAST = CAW'(COLUMNS - 1);
   localparam logic [RNW-1:0] ROW_END  = RNW'(ROWS);
   localparam logic [RNW-1:0] ROW_LAST = RNW'(ROWS - 1);
   localparam logic [RW-1:0]  PHY_LAST = RW'(ROWS - 1);

   function automatic logic [RW-1:0] phys_row(input logic [RW-1:0] base,
                                              input logic [RW-1:0] r);
      logic [RW:0] sum;
      sum = {1'b0, base} + {1'b0, r};
      if (sum >= (RW+1)'(ROWS)) begin
         sum = sum - (RW+1)'(ROWS);
      end
      return sum[RW-1:0];
   endfunction

   state_type         state_ff, state_in;
   logic [CNW-1:0]    col_ff, col_in;
   logic [RNW-1:0]    row_ff, row_in;
   logic [RW-1:0]     top_ff, top_in;
   logic [CNW-1:0]    fill_end_ff, fill_end_in;
   logic [CAW-1:0]    cnt_ff, cnt_in;
   logic [RW-1:0]     clr_row_ff, clr_row_in;
   logic [RW-1:0]     scr_row_ff, scr_row_in;
   logic              scrolled_ff, scrolled_in;
   logic              ignored_ff, ignored_in;
   logic              rd_hit_ff, rd_hit_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0] rsp_cell_ff, rsp_cell_in;
   logic [COL_W-1:0]  rsp_col_ff, rsp_col_in;
   logic [ROW_W-1:0]  rsp_row_ff, rsp_row_in;
   logic              rsp_scrolled_ff, rsp_scrolled_in;
   logic              rsp_ignored_ff, rsp_ignored_in;

   logic [RW-1:0]     cur_phys;
   logic [CNW-1:0]    col_inc;
   logic [RNW-1:0]    row_inc;
   logic [7:0]        col8;
   logic [7:0]        tab_tgt;
   logic [CNW-1:0]    bs_col;
   logic [RNW-1:0]    bs_row;
   logic              rd_in_range;
   logic              printable;

   assign cur_phys    = phys_row(top_ff, RW'(row_ff));
   assign col_inc     = col_ff + CNW'(1);
   assign row_inc     = row_ff + RNW'(1);
   assign col8        = 8'(col_ff);
   assign rd_in_range = (int'(req_read_col) < COLUMNS) && (int'(req_read_row) < ROWS);
   assign printable   = (req_char_code >= CODE_SPACE) && (req_char_code <= CODE_LAST_PRINT);

   always_comb begin
      if (col8 < 8'(tab_stops.first)) begin
         tab_tgt = 8'(tab_stops.first);
      end else if (col8 < 8'(tab_stops.second)) begin
         tab_tgt = 8'(tab_stops.second);
      end else if (col8 < 8'(tab_stops.third)) begin
         tab_tgt = 8'(tab_stops.third);
      end else begin
         tab_tgt = col8;
      end
      if (tab_tgt > 8'(COLUMNS)) begin
         tab_tgt = 8'(COLUMNS);
      end
   end

   always_comb begin
      if (col_ff != '0) begin
         bs_col = col_ff - CNW'(1);
         bs_row = row_ff;
      end else begin
         bs_col = COL_LAST;
         bs_row = (row_ff != '0) ? row_ff - RNW'(1) : row_ff;
      end
   end

   always_comb begin
      state_in        = state_ff;
      col_in          = col_ff;
      row_in          = row_ff;
      top_in          = top_ff;
      fill_end_in     = fill_end_ff;
      cnt_in          = cnt_ff;
      clr_row_in      = clr_row_ff;
      scr_row_in      = scr_row_ff;
      scrolled_in     = scrolled_ff;
      ignored_in      = ignored_ff;
      rd_hit_in       = rd_hit_ff;
      rsp_valid_in    = rsp_valid_ff & rsp_stall;
      rsp_cell_in     = rsp_cell_ff;
      rsp_col_in      = rsp_col_ff;
      rsp_row_in      = rsp_row_ff;
      rsp_scrolled_in = rsp_scrolled_ff;
      rsp_ignored_in  = rsp_ignored_ff;
      mem_wr_en       = 1'b0;
      mem_wr_addr     = {cur_phys, col_ff[CAW-1:0]};
      mem_wr_data     = CODE_SPACE;
      mem_rd_en       = 1'b0;
      mem_rd_addr     = {phys_row(top_ff, RW'(req_read_row)), CAW'(req_read_col)};
      req_stall       = (state_ff != ST_IDLE);

      case (state_ff)
         ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = {clr_row_ff, cnt_ff};
            mem_wr_data = CODE_NULL;
            if (cnt_ff == CNT_LAST) begin
               cnt_in = '0;
               if (clr_row_ff == PHY_LAST) begin
                  state_in = ST_IDLE;
               end else begin
                  clr_row_in = clr_row_ff + RW'(1);
               end
            end else begin
               cnt_in = cnt_ff + CAW'(1);
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               scrolled_in = 1'b0;
               ignored_in  = 1'b0;
               rd_hit_in   = 1'b0;
               if (req_operation == OP_READ) begin
                  rd_hit_in = rd_in_range;
                  mem_rd_en = rd_in_range;
                  state_in  = ST_DONE;
               end else begin
                  case (req_char_code)
                     CODE_TAB: begin
                        if (col8 < tab_tgt) begin
                           fill_end_in = CNW'(tab_tgt);
                           state_in    = ST_FILL;
                        end else begin
                           state_in = ST_CHECK;
                        end
                     end
                     CODE_NL: begin
                        fill_end_in = COL_END;
                        state_in    = ST_FILL;
                     end
                     CODE_BS: begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = {phys_row(top_ff, RW'(bs_row)), bs_col[CAW-1:0]};
                        col_in      = bs_col;
                        row_in      = bs_row;
                        state_in    = ST_CHECK;
                     end
                     default: begin
                        if (printable) begin
                           mem_wr_en   = 1'b1;
                           mem_wr_data = req_char_code;
                           col_in      = col_inc;
                           state_in    = ST_CHECK;
                        end else begin
                           ignored_in = 1'b1;
                           state_in   = ST_DONE;
                        end
                     end
                  endcase
               end
            end
         end
         ST_FILL: begin
            mem_wr_en = 1'b1;
            col_in    = col_inc;
            if (col_inc == fill_end_ff) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            state_in = ST_DONE;
            if (col_ff >= COL_END) begin
               col_in = '0;
               row_in = row_inc;
               if (row_inc >= ROW_END) begin
                  row_in      = ROW_LAST;
                  scrolled_in = 1'b1;
                  scr_row_in  = top_ff;
                  top_in      = (top_ff == PHY_LAST) ? '0 : top_ff + RW'(1);
                  cnt_in      = '0;
                  state_in    = ST_SCROLL;
               end
            end
         end
         ST_SCROLL: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = {scr_row_ff, cnt_ff};
            if (cnt_ff == CNT_LAST) begin
               cnt_in   = '0;
               state_in = ST_DONE;
            end else begin
               cnt_in = cnt_ff + CAW'(1);
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in    = 1'b1;
               rsp_cell_in     = rd_hit_ff ? mem_rd_data : CODE_NULL;
               rsp_col_in      = COL_W'(col_ff);
               rsp_row_in      = ROW_W'(row_ff);
               rsp_scrolled_in = scrolled_ff;
               rsp_ignored_in  = ignored_ff;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         col_ff       <= '0;
         row_ff       <= '0;
         top_ff       <= '0;
         cnt_ff       <= '0;
         clr_row_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         top_ff       <= top_in;
         cnt_ff       <= cnt_in;
         clr_row_ff   <= clr_row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fill_end_ff     <= fill_end_in;
      scr_row_ff      <= scr_row_in;
      scrolled_ff     <= scrolled_in;
      ignored_ff      <= ignored_in;
      rd_hit_ff       <= rd_hit_in;
      rsp_cell_ff     <= rsp_cell_in;
      rsp_col_ff      <= rsp_col_in;
      rsp_row_ff      <= rsp_row_in;
      rsp_scrolled_ff <= rsp_scrolled_in;
      rsp_ignored_ff  <= rsp_ignored_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cell_char  = rsp_cell_ff;
   assign rsp_cursor_col = rsp_col_ff;
   assign rsp_cursor_row = rsp_row_ff;
   assign rsp_scrolled   = rsp_scrolled_ff;
   assign rsp_ignored    = rsp_ignored_ff;

endmodule

// ----- sv/tcb_checker.sv -----
`include "assert_macros.svh"

module tcb_checker import tcb_pkg::*; #(
   parameter int COLUMNS = COLUMNS_DEF
) (
   input logic              clock,
   input logic              reset,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic [CHAR_W-1:0] rsp_cell_char,
   input logic [COL_W-1:0]  rsp_cursor_col,
   input logic              rsp_scrolled,
   input logic              rsp_ignored
);

   `ASSERT_CLK_NR(a_clear_after_reset, clock,
      reset |=> req_stall,
      "no clearing pass after reset")
   `ASSERT_CLK(a_rsp_hold, clock, reset,
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_cursor_col)
         && $stable(rsp_cell_char),
      "stalled transaction changed")
   `ASSERT_CLK(a_scroll_home, clock, reset,
      rsp_valid && rsp_scrolled |-> rsp_cursor_col == '0 && !rsp_ignored,
      "scroll left cursor off column zero")
   `ASSERT_CLK(a_ignored_quiet, clock, reset,
      rsp_valid && rsp_ignored |-> !rsp_scrolled && rsp_cell_char == '0,
      "ignored code had side effects")
   `ASSERT_CLK(a_col_range, clock, reset,
      rsp_valid |-> int'(rsp_cursor_col) < COLUMNS,
      "cursor column out of range")

endmodule

bind text_console_buffer_core tcb_checker #(.COLUMNS(COLUMNS)) u_tcb_checker (.*);

// ----- test/text_console_buffer_core_test.sv -----
`timescale 1ns / 100ps

module text_console_buffer_core_test;
   import tcb_pkg::*;

   localparam int COLUMNS       = COLUMNS_DEF;
   localparam int ROWS          = ROWS_DEF;
   localparam int CIW           = $clog2(COLUMNS);
   localparam int RIW           = $clog2(ROWS);
   localparam int QUIET_LIMIT   = 10000;
   localparam int RANDOM_ITEMS  = 1900;
   localparam int RANDOM_PHASES = 6;

   typedef struct {
      logic [CHAR_W-1:0] cell_char;
      logic [COL_W-1:0]  cursor_col;
      logic [ROW_W-1:0]  cursor_row;
      logic              scrolled;
      logic              ignored;
   } console_report_type;

   logic                  clock         = 1'b0;
   logic                  reset         = 1'b1;
   logic                  csr_wr_en     = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index     = '0;
   logic [CSR_DATA_W-1:0] csr_wdata     = '0;
   logic                  req_valid     = 1'b0;
   logic                  req_stall;
   logic                  req_operation = 1'b0;
   logic [CHAR_W-1:0]     req_char_code = '0;
   logic [COL_W-1:0]      req_read_col  = '0;
   logic [ROW_W-1:0]      req_read_row  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall     = 1'b0;
   logic [CHAR_W-1:0]     rsp_cell_char;
   logic [COL_W-1:0]      rsp_cursor_col;
   logic [ROW_W-1:0]      rsp_cursor_row;
   logic                  rsp_scrolled;
   logic                  rsp_ignored;

   text_console_buffer_core #(
      .COLUMNS(COLUMNS),
      .ROWS   (ROWS)
   ) u_top (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .req_char_code (req_char_code),
      .req_read_col  (req_read_col),
      .req_read_row  (req_read_row),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_cell_char (rsp_cell_char),
      .rsp_cursor_col(rsp_cursor_col),
      .rsp_cursor_row(rsp_cursor_row),
      .rsp_scrolled  (rsp_scrolled),
      .rsp_ignored   (rsp_ignored)
   );

   always #1 clock = ~clock;

   logic [CHAR_W-1:0]     screen_img [ROWS][COLUMNS];
   int                    cur_col;
   int                    cur_row;
   logic [CSR_DATA_W-1:0] stop_first  = TAB_FIRST_RST;
   logic [CSR_DATA_W-1:0] stop_second = TAB_SECOND_RST;
   logic [CSR_DATA_W-1:0] stop_third  = TAB_THIRD_RST;
   console_report_type    pending_reports [$];

   int fail_count;
   int report_count;
   int put_count;
   int read_count;
   int scroll_count;
   int discard_count;
   int quiet_cycles;
   int stall_left;
   bit req_gaps_on   = 1'b1;
   bit rsp_stalls_on = 1'b1;

   function automatic int pick_idle();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60)
         return 0;
      else if (roll < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic void blank_cells(int row, int from_col, int to_col);
      for (int c = from_col; c < to_col; c++)
         screen_img[RIW'(row)][CIW'(c)] = CODE_SPACE;
   endfunction

   function automatic void predict_console(op_type op, logic [CHAR_W-1:0] code,
                                           logic [COL_W-1:0] rcol, logic [ROW_W-1:0] rrow);
      console_report_type rep;
      int                 target;
      bit                 handled;
      rep = '{default: '0};
      handled = 1'b1;
      if (op == OP_READ) begin
         read_count++;
         if (int'(rcol) < COLUMNS && int'(rrow) < ROWS)
            rep.cell_char = screen_img[RIW'(rrow)][CIW'(rcol)];
      end else begin
         put_count++;
         if (code == CODE_TAB) begin
            target = cur_col;
            if (cur_col < int'(stop_first))
               target = int'(stop_first);
            else if (cur_col < int'(stop_second))
               target = int'(stop_second);
            else if (cur_col < int'(stop_third))
               target = int'(stop_third);
            if (target > COLUMNS)
               target = COLUMNS;
            if (target > cur_col) begin
               blank_cells(cur_row, cur_col, target);
               cur_col = target;
            end
         end else if (code == CODE_NL) begin
            blank_cells(cur_row, cur_col, COLUMNS);
            cur_col = 0;
            cur_row++;
         end else if (code == CODE_BS) begin
            if (cur_col != 0) begin
               cur_col--;
            end else begin
               cur_col = COLUMNS - 1;
               if (cur_row != 0)
                  cur_row--;
            end
            screen_img[RIW'(cur_row)][CIW'(cur_col)] = CODE_SPACE;
         end else if (code >= CODE_SPACE && code <= CODE_LAST_PRINT) begin
            screen_img[RIW'(cur_row)][CIW'(cur_col)] = code;
            cur_col++;
         end else begin
            handled = 1'b0;
            rep.ignored = 1'b1;
            discard_count++;
         end
         if (handled) begin
            if (cur_col >= COLUMNS) begin
               cur_col = 0;
               cur_row++;
            end
            if (cur_row >= ROWS) begin
               for (int r = 0; r < ROWS - 1; r++)
                  screen_img[RIW'(r)] = screen_img[RIW'(r + 1)];
               blank_cells(ROWS - 1, 0, COLUMNS);
               cur_row = ROWS - 1;
               cur_col = 0;
               rep.scrolled = 1'b1;
               scroll_count++;
            end
         end
      end
      rep.cursor_col = COL_W'(cur_col);
      rep.cursor_row = ROW_W'(cur_row);
      pending_reports.push_back(rep);
   endfunction

   task automatic send_item(op_type op, logic [CHAR_W-1:0] code,
                            logic [COL_W-1:0] rcol, logic [ROW_W-1:0] rrow);
      int gap;
      @(negedge clock);
      req_operation <= op;
      req_char_code <= code;
      req_read_col  <= rcol;
      req_read_row  <= rrow;
      req_valid     <= 1'b1;
      do @(posedge clock); while (req_stall);
      predict_console(op, code, rcol, rrow);
      gap = req_gaps_on ? pick_idle() : 0;
      if (gap != 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // hold the sender until every expected transaction has come back
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
   endtask

   task automatic set_tab_stops(logic [CSR_DATA_W-1:0] first, logic [CSR_DATA_W-1:0] second,
                                logic [CSR_DATA_W-1:0] third);
      wait_idle();
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_TAB_FIRST;
      csr_wdata <= first;
      @(negedge clock);
      csr_index <= CSR_TAB_SECOND;
      csr_wdata <= second;
      @(negedge clock);
      csr_index <= CSR_TAB_THIRD;
      csr_wdata <= third;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      stop_first  = first;
      stop_second = second;
      stop_third  = third;
   endtask

   task automatic send_random_item();
      int                roll;
      op_type            op;
      logic [CHAR_W-1:0] code;
      logic [COL_W-1:0]  rcol;
      logic [ROW_W-1:0]  rrow;
      roll = $urandom_range(0, 99);
      op   = OP_PUT;
      code = CHAR_W'($urandom_range(CODE_SPACE, CODE_LAST_PRINT));
      rcol = COL_W'($urandom);
      rrow = ROW_W'($urandom);
      if (roll < 15) begin
         op   = OP_READ;
         code = CHAR_W'($urandom);
         if ($urandom_range(0, 9) != 0) begin
            rcol = COL_W'($urandom_range(0, COLUMNS - 1));
            rrow = ROW_W'($urandom_range(0, ROWS - 1));
         end
      end else if (roll < 23) begin
         code = CODE_NL;
      end else if (roll < 31) begin
         code = CODE_TAB;
      end else if (roll < 39) begin
         code = CODE_BS;
      end else if (roll < 45) begin
         do
            code = CHAR_W'($urandom);
         while (code == CODE_TAB || code == CODE_NL || code == CODE_BS ||
                (code >= CODE_SPACE && code <= CODE_LAST_PRINT));
      end
      send_item(op, code, rcol, rrow);
   endtask

   task automatic test_home_and_discards();
      logic [CHAR_W-1:0] discards [5] = '{CODE_NULL, 8'h07, 8'h1f, 8'h80, 8'hff};
      send_item(OP_READ, CODE_NULL, 0, 0);
      send_item(OP_PUT, CODE_BS, 0, 0);
      send_item(OP_READ, CODE_NULL, COL_W'(COLUMNS - 1), 0);
      send_item(OP_PUT, 8'h5a, 0, 0);
      foreach (discards[i])
         send_item(OP_PUT, discards[i], '1, '1);
      send_item(OP_PUT, CODE_SPACE, 0, 0);
      send_item(OP_PUT, CODE_LAST_PRINT, 0, 0);
      repeat (4) send_item(OP_PUT, CODE_TAB, 0, 0);
      send_item(OP_PUT, CODE_NL, 0, 0);
      send_item(OP_PUT, CODE_BS, 0, 0);
      send_item(OP_READ, CODE_NULL, COL_W'(COLUMNS - 1), 0);
      send_item(OP_READ, 8'hff, '1, '1);
      send_item(OP_READ, CODE_NULL, COL_W'(COLUMNS), 0);
      send_item(OP_READ, CODE_NULL, 0, ROW_W'(ROWS));
   endtask

   task automatic test_tab_stop_order();
      set_tab_stops(7'd40, 7'd5, '1);
      send_item(OP_PUT, CODE_NL, 0, 0);
      send_item(OP_PUT, CODE_TAB, 0, 0);
      send_item(OP_PUT, CODE_TAB, 0, 0);
      send_item(OP_PUT, CODE_TAB, 0, 0);
      set_tab_stops('0, '0, '0);
      send_item(OP_PUT, CODE_TAB, 0, 0);
      send_item(OP_PUT, 8'h41, 0, 0);
   endtask

   task automatic test_random_text();
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: set_tab_stops(TAB_FIRST_RST, TAB_SECOND_RST, TAB_THIRD_RST);
            1: set_tab_stops('0, '0, '0);
            2: set_tab_stops(CSR_DATA_W'(COLUMNS - 1), CSR_DATA_W'(COLUMNS - 1),
                             CSR_DATA_W'(COLUMNS - 1));
            3: set_tab_stops('1, CSR_DATA_W'(COLUMNS / 2), 7'd3);
            4: set_tab_stops(CSR_DATA_W'($urandom_range(0, COLUMNS - 1)),
                             CSR_DATA_W'($urandom_range(0, COLUMNS - 1)),
                             CSR_DATA_W'($urandom_range(0, COLUMNS - 1)));
            default: set_tab_stops(CSR_DATA_W'($urandom), CSR_DATA_W'($urandom),
                                   CSR_DATA_W'($urandom));
         endcase
         req_gaps_on   = (phase != 0) && (phase != 3);
         rsp_stalls_on = (phase != 0) && (phase != 2);
         repeat (RANDOM_ITEMS / RANDOM_PHASES) send_random_item();
      end
   endtask

   always @(negedge clock) begin
      if (stall_left == 0 && rsp_stalls_on && $urandom_range(0, 3) == 0)
         stall_left = pick_idle();
      rsp_stall <= (stall_left != 0);
      if (stall_left != 0)
         stall_left--;
   end

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         fail_count++;
         $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
      end
   endfunction

   always @(posedge clock) begin
      console_report_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_reports.size() == 0) begin
            fail_count++;
            $display("%0t: transaction with nothing expected, cursor %0d/%0d", $time,
                     rsp_cursor_col, rsp_cursor_row);
         end else begin
            want = pending_reports.pop_front();
            report_count++;
            check_field("cell_char", 32'(want.cell_char), 32'(rsp_cell_char));
            check_field("cursor_col", 32'(want.cursor_col), 32'(rsp_cursor_col));
            check_field("cursor_row", 32'(want.cursor_row), 32'(rsp_cursor_row));
            check_field("scrolled", 32'(want.scrolled), 32'(rsp_scrolled));
            check_field("ignored", 32'(want.ignored), 32'(rsp_ignored));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      foreach (screen_img[r, c])
         screen_img[r][c] = '0;
      cur_col = 0;
      cur_row = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_home_and_discards();
      test_tab_stop_order();
      test_random_text();

      wait_idle();
      repeat (2 * COLUMNS + 8) @(posedge clock);
      $display("checked %0d transactions: %0d puts with %0d scrolls and %0d discarded codes,",
               report_count, put_count, scroll_count, discard_count);
      $display("%0d cell reads, tab stops swept over zero, last column, beyond-row, unordered",
               read_count);
      if (fail_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+sv
sv/tcb_pkg.sv
sv/tcb_store.sv
sv/tcb_ctrl.sv
sv/text_console_buffer_core.sv
sv/tcb_checker.sv
test/text_console_buffer_core_test.sv
